// ===== sv/palette_symbol_encoder_assert.svh =====
`ifndef PALETTE_SYMBOL_ENCODER_ASSERT_SVH
`define PALETTE_SYMBOL_ENCODER_ASSERT_SVH

// Both macros expect clk and rst_n in scope.

// Same-cycle implication.
`define PSE_ASSERT_NOW(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSE_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pse_pkg.sv =====
package pse_pkg;

    localparam int unsigned CHAN_W        = 8;
    localparam int unsigned RGB_W         = 3 * CHAN_W;
    localparam int unsigned COUNT_W       = 7;
    localparam int unsigned IDX_W         = 7;
    localparam int unsigned SYM_W         = 8;
    localparam int unsigned ALPHABET_SIZE = 74;
    localparam int unsigned MAX_COLORS_DEF = 74;

    // first character sits in the top byte
    localparam logic [SYM_W*ALPHABET_SIZE-1:0] SYMBOL_STR =
        "*!#$&/()=-.,ZXCVBNMLKJHGFDSAQWERTYUIOPplokmijnuhbygvtfcrdxeszwaq2134567890";

    typedef struct packed {
        logic               wr_en;
        logic [COUNT_W-1:0] count;
        logic [RGB_W-1:0]   rgb;
    } pse_cell_ctrl_t;

    function automatic logic [SYM_W-1:0] symbol_at(input logic [IDX_W-1:0] idx);
        int unsigned pos;
        pos = int'(idx);
        if (pos >= ALPHABET_SIZE)
        begin
            return '0;
        end
        return SYMBOL_STR[SYM_W*(ALPHABET_SIZE-1-pos) +: SYM_W];
    endfunction

endpackage

// ===== sv/pse_if.sv =====
interface pse_pixel_if import pse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              start_of_image;

    modport source (output valid, red, green, blue, start_of_image, input ready);
    modport sink   (input valid, red, green, blue, start_of_image, output ready);
endinterface

interface pse_symbol_if import pse_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] palette_index;
    logic             is_new;
    logic             overflow;

    modport source (output valid, symbol, palette_index, is_new, overflow, input ready);
    modport sink   (input valid, symbol, palette_index, is_new, overflow, output ready);
endinterface

// ===== sv/pse_cell.sv =====
module pse_cell import pse_pkg::*; #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic           clk,
    input  pse_cell_ctrl_t ctrl,
    output logic           hit
);

    logic [RGB_W-1:0] colour_reg;
    logic             occupied;

    // entries below the fill count are live; those at or above it never report a hit
    assign occupied = ctrl.count > COUNT_W'(CELL_IDX);
    assign hit      = occupied && (colour_reg == ctrl.rgb);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && (ctrl.count == COUNT_W'(CELL_IDX)))
        begin
            colour_reg <= ctrl.rgb;
        end
    end

endmodule

// ===== sv/pse_match_enc.sv =====
module pse_match_enc import pse_pkg::*; #(
    parameter int unsigned N = MAX_COLORS_DEF
) (
    input  logic [N-1:0]     hit,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    // palette colours are distinct, so at most one hit bit is set
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (hit[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
    end

    assign found = |hit;

endmodule

// ===== sv/palette_symbol_encoder.sv =====
// Palette symbol encoder. Each pixel beat is compared against every palette
// entry at once, one cell per entry, and the result beat appears in the output
// register on the next cycle: one pixel per cycle sustained while the output is
// not stalled; the parallel colour compare and the index encode sit in front of
// the output register. A new colour takes the next free entry; start_of_image
// empties the palette before its own pixel. An unknown colour on a full palette
// gives overflow with symbol and index zero. No clearing pass after reset.
module palette_symbol_encoder import pse_pkg::*; #(
    parameter int unsigned MAX_COLORS = MAX_COLORS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    pse_pixel_if.sink           pixel_in,
    pse_symbol_if.source        symbol_out
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_eff;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SYM_W-1:0]   symbol_reg;
    logic [IDX_W-1:0]   index_reg;
    logic               is_new_reg;
    logic               overflow_reg;

    logic               in_fire;
    logic               found;
    logic [IDX_W-1:0]   hit_idx;
    logic [MAX_COLORS-1:0] hit;
    logic               room;
    logic               insert;
    logic [IDX_W-1:0]   res_idx;
    pse_cell_ctrl_t     cell_ctrl;

    assign pixel_in.ready = !out_valid_reg || symbol_out.ready;
    assign in_fire        = pixel_in.valid && pixel_in.ready;

    assign count_eff = pixel_in.start_of_image ? '0 : count_reg;
    assign room      = count_eff < COUNT_W'(MAX_COLORS);
    assign insert    = !found && room;

    assign cell_ctrl.wr_en = in_fire && insert;
    assign cell_ctrl.count = count_eff;
    assign cell_ctrl.rgb   = {pixel_in.red, pixel_in.green, pixel_in.blue};

    for (genvar g = 0; g < MAX_COLORS; g++)
    begin : g_cell
        pse_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk  (clk),
            .ctrl (cell_ctrl),
            .hit  (hit[g])
        );
    end

    pse_match_enc #(
        .N (MAX_COLORS)
    ) u_enc (
        .hit   (hit),
        .found (found),
        .idx   (hit_idx)
    );

    assign res_idx = found ? hit_idx : (insert ? IDX_W'(count_eff) : '0);

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (symbol_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            count_next     = insert ? count_eff + COUNT_W'(1) : count_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            symbol_reg   <= (found || insert) ? symbol_at(res_idx) : '0;
            index_reg    <= res_idx;
            is_new_reg   <= insert;
            overflow_reg <= !found && !room;
        end
    end

    assign symbol_out.valid         = out_valid_reg;
    assign symbol_out.symbol        = symbol_reg;
    assign symbol_out.palette_index = index_reg;
    assign symbol_out.is_new        = is_new_reg;
    assign symbol_out.overflow      = overflow_reg;

endmodule

// ===== sv/pse_checker.sv =====
`include "palette_symbol_encoder_assert.svh"

module pse_checker import pse_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             start_of_image,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SYM_W-1:0] symbol,
    input logic [IDX_W-1:0] palette_index,
    input logic             is_new,
    input logic             overflow
);

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    `PSE_ASSERT_NEXT(a_beat_lands, in_fire, out_valid, "accepted pixel gave no result beat")

    `PSE_ASSERT_NEXT(a_sof_entry0, in_fire && start_of_image,
        is_new && !overflow && (palette_index == '0), "start pixel not entered as entry 0")

    `PSE_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with output empty")

    `PSE_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(symbol) && $stable(palette_index), "stalled result changed")

endmodule

bind palette_symbol_encoder pse_checker u_pse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pixel_in.valid),
    .in_ready       (pixel_in.ready),
    .start_of_image (pixel_in.start_of_image),
    .out_valid      (symbol_out.valid),
    .out_ready      (symbol_out.ready),
    .symbol         (symbol_out.symbol),
    .palette_index  (symbol_out.palette_index),
    .is_new         (symbol_out.is_new),
    .overflow       (symbol_out.overflow)
);
